FILE: sv/sps_pkg.sv
package sps_pkg;

    // fixed field widths of the item, result and config
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 17;
    localparam int PLEN_REG_W  = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int PAT_SLOTS   = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES_HIGH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_REVERSE     = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              first_byte;
        logic              last_byte;
        logic [POS_W-1:0]  search_limit;
    } in_item_t;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_position;
    } out_item_t;

    typedef struct packed {
        logic [PLEN_REG_W-1:0]             pattern_length;
        logic [PAT_SLOTS-1:0][BYTE_W-1:0]  pattern_bytes;
        logic                              search_reverse;
    } cfg_t;

endpackage

FILE: sv/sps_cfg_regs.sv
module sps_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [sps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sps_pkg::cfg_t                     cfg
);
    import sps_pkg::*;

    cfg_t cfg_reg;

    // config port is always ready, so valid alone marks a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH:
                begin
                    cfg_reg.pattern_length <= cfg_data[PLEN_REG_W-1:0];
                end
                CFG_PATTERN_BYTES_LOW:
                begin
                    cfg_reg.pattern_bytes[7:0] <= cfg_data;
                end
                CFG_PATTERN_BYTES_HIGH:
                begin
                    cfg_reg.pattern_bytes[15:8] <= cfg_data;
                end
                CFG_SEARCH_REVERSE:
                begin
                    cfg_reg.search_reverse <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/sps_match.sv
module sps_match #(
    parameter int MAX_PATTERN = 16,
    parameter int PLW         = 5
) (
    input  logic [MAX_PATTERN-1:0][sps_pkg::BYTE_W-1:0]        window,
    input  logic [sps_pkg::PAT_SLOTS-1:0][sps_pkg::BYTE_W-1:0] pattern,
    input  logic [PLW-1:0]                                     plen,
    output logic                                               match
);
    import sps_pkg::*;

    // hit[p]: the newest p window bytes equal pattern bytes 0..p-1
    logic [MAX_PATTERN:0] hit;

    always_comb
    begin
        hit = '0;
        for (int p = 1; p <= MAX_PATTERN; p++)
        begin
            hit[p] = 1'b1;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (j < p)
                begin
                    if (pattern[j] != window[p-1-j])
                    begin
                        hit[p] = 1'b0;
                    end
                end
            end
        end
    end

    assign match = hit[plen];

endmodule

FILE: sv/substring_position_search.sv
// streaming substring search over a byte text
// item channel (item_valid/item_ready/item): one text byte per item; first_byte
//   restarts the text and samples search_limit, last_byte asks for the result
// result channel (result_valid/result_ready/result): one result per last byte,
//   match_found and match_position (zero when nothing found)
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, write
//   only while no item is in flight
// an accepted item is held in the input register and processed from there into the search
//   state; a last byte's result is then registered in the result register
// throughput: one item per cycle unless a last byte waits on a stalled result; set by
//   the single registered compare stage that matches the pattern against the byte window
// a stalled result register holds the next last-byte item in the input
//   register; other items keep flowing past a stalled output
// reset clears the window, counters, config and both valid flags
module substring_position_search #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  sps_pkg::in_item_t                 item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output sps_pkg::out_item_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sps_pkg::*;

    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int CW  = $clog2(MAX_TEXT + 1);
    localparam int LW  = (CW > POS_W) ? CW : POS_W;

    cfg_t cfg;

    // input register
    logic      in_valid_reg;
    in_item_t  in_reg;

    // search state
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_next;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [POS_W-1:0]                   limit_reg;
    logic [POS_W-1:0]                   limit_next;
    logic                               found_reg;
    logic                               found_next;
    logic [CW-1:0]                      best_reg;
    logic [CW-1:0]                      best_next;

    // output register
    logic       result_valid_reg;
    out_item_t  result_reg;
    out_item_t  result_next;

    logic           advance;
    logic [PLW-1:0] plen;
    logic           window_hit;
    logic           take;
    logic [CW-1:0]  start_pos;
    logic [LW-1:0]  final_count;
    logic [LW-1:0]  limit_wide;

    sps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    // a buffered item moves on unless it needs the result register and that is full and not being taken
    assign advance    = in_valid_reg
                        && (!in_reg.last_byte || !result_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    // oversized pattern lengths saturate
    assign plen = (cfg.pattern_length > PLEN_REG_W'(MAX_PATTERN))
                  ? PLW'(MAX_PATTERN) : PLW'(cfg.pattern_length);

    // bytes past the text capacity are dropped; a first byte always restarts at zero
    assign take = in_reg.first_byte || (count_reg < CW'(MAX_TEXT));

    // window shift, newest byte in slot 0
    always_comb
    begin
        window_next = window_reg;
        if (take)
        begin
            for (int i = MAX_PATTERN - 1; i > 0; i--)
            begin
                window_next[i] = window_reg[i-1];
            end
            window_next[0] = in_reg.text_byte;
        end
    end

    sps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .PLW         (PLW)
    ) u_match (
        .window  (window_next),
        .pattern (cfg.pattern_bytes),
        .plen    (plen),
        .match   (window_hit)
    );

    always_comb
    begin
        count_next  = in_reg.first_byte ? '0 : count_reg;
        limit_next  = in_reg.first_byte ? in_reg.search_limit : limit_reg;
        found_next  = in_reg.first_byte ? 1'b0 : found_reg;
        best_next   = in_reg.first_byte ? '0 : best_reg;
        start_pos   = '0;

        if (take)
        begin
            count_next = count_next + CW'(1);
            start_pos  = count_next - CW'(plen);
            if (plen != '0 && count_next >= CW'(plen) && window_hit)
            begin
                if (cfg.search_reverse)
                begin
                    if (LW'(start_pos) <= LW'(limit_next))
                    begin
                        found_next = 1'b1;
                        best_next  = start_pos;
                    end
                end
                else if (!found_next && LW'(start_pos) >= LW'(limit_next))
                begin
                    found_next = 1'b1;
                    best_next  = start_pos;
                end
            end
        end

        // final result; an empty pattern matches at every position
        final_count = LW'(count_next);
        limit_wide  = LW'(limit_next);
        result_next = '0;
        if (plen == '0)
        begin
            if (cfg.search_reverse)
            begin
                result_next.match_found    = 1'b1;
                result_next.match_position = (limit_wide < final_count)
                                             ? limit_next : final_count[POS_W-1:0];
            end
            else if (limit_wide <= final_count)
            begin
                result_next.match_found    = 1'b1;
                result_next.match_position = limit_next;
            end
        end
        else if (found_next)
        begin
            result_next.match_found    = 1'b1;
            result_next.match_position = POS_W'(best_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            window_reg       <= '0;
            count_reg        <= '0;
            limit_reg        <= '0;
            found_reg        <= 1'b0;
            best_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                window_reg <= window_next;
                count_reg  <= count_next;
                limit_reg  <= limit_next;
                found_reg  <= found_next;
                best_reg   <= best_next;
            end
            if (advance && in_reg.last_byte)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
        if (advance && in_reg.last_byte)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sps_pkg::*;

    localparam int MAX_PAT         = 16;
    localparam int MAX_TEXT_LEN    = 65536;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1200;

    typedef bit [7:0] byte_seq_t[$];

    // block ports, every input known from time zero
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    in_item_t           item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    out_item_t          result;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PATTERN_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // text bytes waiting to be offered, and search results still owed by the block
    in_item_t  pending_bytes[$];
    out_item_t owed_results[$];

    // handshake bookkeeping between the processes
    bit item_taken     = 1'b0;
    int send_gap       = 0;
    int recv_gap       = 0;
    bit no_idle        = 1'b0;
    bit start_hold_off = 1'b0;
    bit hold_off       = 1'b0;

    // run statistics
    int errors          = 0;
    int results_checked = 0;
    int matches_seen    = 0;
    int bytes_accepted  = 0;
    int settings_used   = 0;

    // shadow of the configuration registers
    bit [4:0]   cur_plen    = '0;
    bit [127:0] cur_pattern = '0;
    bit         cur_reverse = 1'b0;

    // search state of the text in progress; window_bytes[0] is the newest byte
    bit [7:0]    window_bytes[MAX_PAT];
    int unsigned text_len    = 0;
    bit [16:0]   start_limit = '0;
    bit          have_match  = 1'b0;
    bit [16:0]   match_start = '0;

    substring_position_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle length: mostly short, now and then a long pause
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void report_mismatch(string field, int unsigned want, int unsigned got);
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    // advance the search by one accepted text byte; a last byte owes one result
    function automatic void search_step(in_item_t it);
        int unsigned plen;
        int unsigned k;
        bit          hit;
        bit [16:0]   s;
        out_item_t   res;
        plen = (cur_plen > MAX_PAT) ? MAX_PAT : cur_plen;
        if (it.first_byte)
        begin
            text_len    = 0;
            have_match  = 1'b0;
            match_start = '0;
            start_limit = it.search_limit;
        end
        // bytes past the text length cap are dropped entirely
        if (text_len < MAX_TEXT_LEN)
        begin
            for (k = MAX_PAT - 1; k > 0; k--)
                window_bytes[k] = window_bytes[k - 1];
            window_bytes[0] = it.text_byte;
            text_len++;
            if (plen > 0 && text_len >= plen)
            begin
                hit = 1'b1;
                for (k = 0; k < plen; k++)
                    if (cur_pattern[8*k +: 8] != window_bytes[plen - 1 - k])
                        hit = 1'b0;
                if (hit)
                begin
                    s = 17'(text_len - plen);
                    // reverse keeps the latest start in range, forward the earliest
                    if (cur_reverse)
                    begin
                        if (s <= start_limit)
                        begin
                            have_match  = 1'b1;
                            match_start = s;
                        end
                    end
                    else if (!have_match && s >= start_limit)
                    begin
                        have_match  = 1'b1;
                        match_start = s;
                    end
                end
            end
        end
        if (it.last_byte)
        begin
            if (plen == 0)
            begin
                // empty pattern matches at every position up to the text length
                if (cur_reverse)
                begin
                    res.match_found    = 1'b1;
                    res.match_position = (start_limit < text_len) ? start_limit
                                                                  : 17'(text_len);
                end
                else if (start_limit <= text_len)
                begin
                    res.match_found    = 1'b1;
                    res.match_position = start_limit;
                end
                else
                    res = '0;
            end
            else
            begin
                res.match_found    = have_match;
                res.match_position = have_match ? match_start : 17'd0;
            end
            owed_results.push_back(res);
        end
    endfunction

    // driver: offers queued text bytes at the falling edge, pausing after some items
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_taken)
        begin
            if (item_taken)
            begin
                item_taken = 1'b0;
                send_gap   = (no_idle || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                item       <= pending_bytes[0];
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver: random stalls, overridden by the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            result_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            result_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < 15)
        begin
            recv_gap = pick_gap() - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (start_hold_off);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // monitor: checks results against the oldest owed one, then predicts accepted items
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with none owed, found %0d position %0d",
                             $time, result.match_found, result.match_position);
                end
                else
                begin
                    want = owed_results.pop_front();
                    results_checked++;
                    if (want.match_found)
                        matches_seen++;
                    if (result.match_found !== want.match_found)
                        report_mismatch("match_found", want.match_found,
                                        result.match_found);
                    if (result.match_position !== want.match_position)
                        report_mismatch("match_position", want.match_position,
                                        result.match_position);
                end
            end
            if (item_valid && item_ready)
            begin
                search_step(item);
                void'(pending_bytes.pop_front());
                item_taken = 1'b1;
                bytes_accepted++;
            end
        end
    end

    // block is idle: nothing queued or offered, nothing owed, pipeline flushed
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || item_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PATTERN_LENGTH:     cur_plen            = value[4:0];
            CFG_PATTERN_BYTES_LOW:  cur_pattern[63:0]   = value;
            CFG_PATTERN_BYTES_HIGH: cur_pattern[127:64] = value;
            CFG_SEARCH_REVERSE:     cur_reverse         = value[0];
            default: ;
        endcase
    endtask

    // new search setting, written only once the block has gone idle
    task automatic configure(int unsigned plen, bit [127:0] pat, bit reverse);
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, 64'(plen));
        write_reg(CFG_PATTERN_BYTES_LOW, pat[63:0]);
        write_reg(CFG_PATTERN_BYTES_HIGH, pat[127:64]);
        write_reg(CFG_SEARCH_REVERSE, 64'(reverse));
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // limit only matters on a first byte, elsewhere it carries noise
    task automatic queue_text(byte_seq_t seq, bit [16:0] limit, bit mark_first, bit mark_last);
        in_item_t it;
        foreach (seq[i])
        begin
            it.text_byte    = seq[i];
            it.first_byte   = mark_first && (i == 0);
            it.last_byte    = mark_last && (i == seq.size() - 1);
            it.search_limit = it.first_byte ? limit : 17'($urandom_range(0, 65536));
            pending_bytes.push_back(it);
        end
    endtask

    // random text with up to two copies of the pattern planted in it
    function automatic byte_seq_t make_text(int unsigned n, int unsigned plen, bit narrow,
                                            bit [127:0] pat);
        byte_seq_t   s;
        int unsigned at;
        int unsigned k;
        int unsigned copies;
        for (k = 0; k < n; k++)
            s.push_back(narrow ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255)));
        if (plen > 0 && n >= plen)
        begin
            copies = $urandom_range(0, 2);
            repeat (copies)
            begin
                at = $urandom_range(0, n - plen);
                for (k = 0; k < plen; k++)
                    s[at + k] = pat[8*k +: 8];
            end
        end
        return s;
    endfunction

    initial
    begin
        byte_seq_t   seq;
        bit [127:0]  pat;
        bit [16:0]   lim;
        bit          narrow;
        int unsigned plen;
        int unsigned eff_len;
        int unsigned n;
        int unsigned k;
        int unsigned kind;
        int unsigned phase_items;
        int unsigned random_items;

        random_items = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting, no first byte: continues the empty text with limit 0
        seq = '{8'hAA};
        queue_text(seq, 17'd0, 1'b0, 1'b1);

        // forward search skips the match below the limit
        configure(3, 128'h636261, 1'b0);
        seq = '{8'h00, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63};
        queue_text(seq, 17'd2, 1'b1, 1'b1);

        // reverse search with the largest limit takes the last match
        configure(3, 128'h636261, 1'b1);
        seq = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'hFF};
        queue_text(seq, 17'd65536, 1'b1, 1'b1);

        // oversized length saturates to a full pattern, longer than the text
        configure(31, {128{1'b1}}, 1'b0);
        seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_text(seq, 17'd0, 1'b1, 1'b1);

        // empty pattern: reverse clamps to the text length, forward misses past it
        configure(0, '0, 1'b1);
        seq = '{8'h42};
        queue_text(seq, 17'd5, 1'b1, 1'b1);
        configure(0, '0, 1'b0);
        queue_text(seq, 17'd2, 1'b1, 1'b1);

        // random phases: one setting each, mostly well-formed texts, some broken
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       plen = 0;
                1, 9:    plen = 16;
                2:       plen = $urandom_range(17, 31);
                3, 4:    plen = $urandom_range(1, 3);
                5, 6:    plen = $urandom_range(4, 8);
                default: plen = $urandom_range(9, 15);
            endcase
            // a narrow alphabet gives overlapping and repeated matches
            narrow = 1'($urandom_range(0, 1));
            for (k = 0; k < 16; k++)
                pat[8*k +: 8] = narrow ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
            configure(plen, pat, 1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            eff_len = (plen > MAX_PAT) ? MAX_PAT : plen;
            phase_items = 0;
            while (phase_items < 150)
            begin
                n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, eff_len + 8)
                                               : $urandom_range(1, 80);
                seq = make_text(n, eff_len, narrow, pat);
                case ($urandom_range(0, 7))
                    0:       lim = 17'd0;
                    1:       lim = 17'd65536;
                    2:       lim = 17'($urandom_range(0, 65536));
                    default: lim = 17'($urandom_range(0, n + 2));
                endcase
                // rarely drop the first marker (text continues) or the last one
                kind = $urandom_range(0, 19);
                queue_text(seq, lim, kind != 0, kind != 1);
                phase_items += n;
            end
            random_items += phase_items;
        end

        // back pressure: short texts while the receiver holds off
        configure(1, 128'($urandom_range(0, 255)), 1'b0);
        no_idle = 1'b1;
        start_hold_off = 1'b1;
        for (k = 0; k < 80; k++)
        begin
            seq = make_text($urandom_range(1, 2), 1, 1'b0, cur_pattern);
            queue_text(seq, 17'($urandom_range(0, 2)), 1'b1, 1'b1);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        $display("searched %0d text bytes under %0d settings, including a long receiver stall",
                 bytes_accepted, settings_used);
        $display("checked %0d results, %0d reporting a match", results_checked, matches_seen);
        if (errors == 0)
            $display("[substring_position_search] OK");
        else
            $display("[substring_position_search] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #15_000_000;
        $display("[substring_position_search] ERROR");
        $finish;
    end

endmodule
